// ===== sv/sfa_pkg.sv =====
// Shared types, codes and constants of the stack slot first-fit allocator.
// Used by every module of the block but sfa_ram; depends on nothing else.
`default_nettype none

package sfa_pkg;

    localparam int DEF_MAX_SCOPES = 16;
    localparam int DEF_MAX_HOLES  = 16;

    localparam int SP_W = 17;
    localparam logic signed [SP_W-1:0] SP_INIT  = -17'sd8;
    localparam logic signed [SP_W-1:0] SP_FLOOR = -17'sd32768;
    localparam logic signed [15:0]     OFF_SAT  = -16'sd32768;
    localparam logic [3:0] SLOT_BYTES = 4'd8;
    localparam logic [3:0] MIN_SIZE   = 4'd1;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_OPEN  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_INT   = 2'd1;
    localparam logic [1:0] KIND_FLOAT = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_DROPPED   = 3'd1;
    localparam logic [2:0] STAT_EXHAUSTED = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;

    localparam logic [1:0] REG_CHAR_BYTES  = 2'd0;
    localparam logic [1:0] REG_INT_BYTES   = 2'd1;
    localparam logic [1:0] REG_FLOAT_BYTES = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] var_kind;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] offset;
        logic [3:0]         granted_bytes;
        logic [2:0]         status;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] base;
        logic [3:0]         free;
    } hole_t;

    typedef struct packed {
        logic               fit;
        logic signed [15:0] offset;
        logic [3:0]         remain;
    } place_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_SHIFT,
        S_NEW
    } state_t;

endpackage

`default_nettype wire

// ===== sv/sfa_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module sfa_ram #(
    parameter int WIDTH = 20,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:(1<<AW)-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/sfa_place.sv =====
// Shared placement unit: fit check, top-of-room placement and alignment.
// Depends on sfa_pkg.
`default_nettype none

module sfa_place
    import sfa_pkg::*;
(
    input  logic signed [SP_W-1:0] base,
    input  logic [3:0]             room,
    input  logic [3:0]             size,
    output place_res_t             res
);

    logic signed [SP_W-1:0] raw;
    logic signed [SP_W-1:0] aligned;
    logic                   pow2;
    logic [3:0]             extra;
    logic [3:0]             used;

    always_comb
    begin
        raw     = base + $signed({13'd0, room}) - $signed({13'd0, size});
        pow2    = (size == 4'd2) || (size == 4'd4) || (size == 4'd8);
        extra   = pow2 ? (raw[3:0] & (size - 4'd1)) : 4'd0;
        aligned = raw - $signed({13'd0, extra});
        used    = size + extra;
        res.fit    = (room >= size);
        res.offset = aligned[15:0];
        res.remain = room - used;
    end

endmodule

`default_nettype wire

// ===== sv/sfa_ctrl.sv =====
// Sequencer of the allocator: scope stack, first-fit hole scan, hole removal
// and new-slot opening. Depends on sfa_pkg, sfa_ram and sfa_place.
`default_nettype none

module sfa_ctrl
    import sfa_pkg::*;
#(
    parameter int MAX_SCOPES = DEF_MAX_SCOPES,
    parameter int MAX_HOLES  = DEF_MAX_HOLES
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  cmd,
    input  logic [3:0] req_size,
    output logic      busy,
    output logic      result_valid,
    output out_item_t result
);

    localparam int SW = $clog2(MAX_SCOPES);
    localparam int DW = $clog2(MAX_SCOPES + 1);
    localparam int HW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam int SCOPE_W = SP_W + CW;

    state_t                 state_reg, state_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic signed [SP_W-1:0] cur_sp_reg, cur_sp_next;
    logic [CW-1:0]          cur_cnt_reg, cur_cnt_next;
    logic [3:0]             size_reg, size_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic [HW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic                   res_valid_reg, res_valid_next;
    out_item_t              res_reg, res_next;

    logic [SW-1:0]          scope_idx;
    logic                   scope_we;
    logic [SW-1:0]          scope_raddr;
    logic [SCOPE_W-1:0]     scope_rdata;

    logic                   hole_we;
    logic [SW+HW-1:0]       hole_waddr;
    hole_t                  hole_wdata;
    logic [SW+HW-1:0]       hole_raddr;
    logic [$bits(hole_t)-1:0] hole_rdata;
    hole_t                  hole_rd;

    logic signed [SP_W-1:0] pl_base;
    logic [3:0]             pl_room;
    place_res_t             pl_res;
    logic                   issue;

    assign scope_idx   = SW'(depth_reg - DW'(1));
    assign scope_raddr = SW'(depth_reg - DW'(2));
    assign hole_raddr  = {scope_idx, rd_idx_reg[HW-1:0]};
    assign hole_rd     = hole_t'(hole_rdata);
    assign issue       = (rd_idx_reg < cur_cnt_reg);

    sfa_ram #(
        .WIDTH (SCOPE_W),
        .AW    (SW)
    ) u_scope_ram (
        .clk   (clk),
        .we    (scope_we),
        .waddr (scope_idx),
        .wdata ({cur_sp_reg, cur_cnt_reg}),
        .raddr (scope_raddr),
        .rdata (scope_rdata)
    );

    sfa_ram #(
        .WIDTH ($bits(hole_t)),
        .AW    (SW + HW)
    ) u_hole_ram (
        .clk   (clk),
        .we    (hole_we),
        .waddr (hole_waddr),
        .wdata (hole_wdata),
        .raddr (hole_raddr),
        .rdata (hole_rdata)
    );

    always_comb
    begin
        if (state_reg == S_NEW)
        begin
            pl_base = cur_sp_reg;
            pl_room = SLOT_BYTES;
        end
        else
        begin
            pl_base = SP_W'(hole_rd.base);
            pl_room = hole_rd.free;
        end
    end

    sfa_place u_place (
        .base (pl_base),
        .room (pl_room),
        .size (size_reg),
        .res  (pl_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= DW'(1);
            cur_sp_reg    <= SP_INIT;
            cur_cnt_reg   <= '0;
            rd_idx_reg    <= '0;
            chk_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            cur_sp_reg    <= cur_sp_next;
            cur_cnt_reg   <= cur_cnt_next;
            rd_idx_reg    <= rd_idx_next;
            chk_idx_reg   <= chk_idx_next;
            chk_valid_reg <= chk_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        cur_sp_next    = cur_sp_reg;
        cur_cnt_next   = cur_cnt_reg;
        size_next      = size_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        scope_we       = 1'b0;
        hole_we        = 1'b0;
        hole_waddr     = {scope_idx, chk_idx_reg};
        hole_wdata     = hole_rd;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    size_next      = req_size;
                    res_next       = '0;
                    res_valid_next = 1'b1;
                    unique case (cmd.op)
                        OP_OPEN:
                        begin
                            if (depth_reg >= DW'(MAX_SCOPES))
                            begin
                                res_next.status = STAT_FULL;
                            end
                            else
                            begin
                                scope_we     = (depth_reg != '0);
                                cur_sp_next  = SP_INIT;
                                cur_cnt_next = '0;
                                depth_next   = depth_reg + DW'(1);
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (depth_reg == '0)
                            begin
                                res_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                res_next.offset = (cur_sp_reg < SP_FLOOR) ?
                                                  OFF_SAT : cur_sp_reg[15:0];
                                depth_next = depth_reg - DW'(1);
                                if (depth_reg >= DW'(2))
                                begin
                                    state_next = S_LOAD;
                                end
                            end
                        end
                        OP_ALLOC:
                        begin
                            if (depth_reg == '0)
                            begin
                                res_next.status = STAT_EMPTY;
                            end
                            else if (cmd.var_kind != KIND_NONE)
                            begin
                                res_valid_next = 1'b0;
                                rd_idx_next    = '0;
                                chk_valid_next = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                {cur_sp_next, cur_cnt_next} = scope_rdata;
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                chk_valid_next = issue;
                chk_idx_next   = rd_idx_reg[HW-1:0];
                if (chk_valid_reg && pl_res.fit)
                begin
                    res_valid_next         = 1'b1;
                    res_next.offset        = pl_res.offset;
                    res_next.granted_bytes = size_reg;
                    res_next.status        = STAT_OK;
                    if (pl_res.remain != '0)
                    begin
                        hole_we         = 1'b1;
                        hole_wdata.base = hole_rd.base;
                        hole_wdata.free = pl_res.remain;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if (!issue)
                begin
                    state_next = S_NEW;
                end
            end

            S_SHIFT:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                chk_valid_next = issue;
                chk_idx_next   = rd_idx_reg[HW-1:0];
                if (chk_valid_reg)
                begin
                    hole_we    = 1'b1;
                    hole_waddr = {scope_idx, chk_idx_reg - HW'(1)};
                    hole_wdata = hole_rd;
                end
                else if (!issue)
                begin
                    cur_cnt_next = cur_cnt_reg - CW'(1);
                    state_next   = S_IDLE;
                end
            end

            S_NEW:
            begin
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
                if (cur_sp_reg < SP_FLOOR)
                begin
                    res_next        = '0;
                    res_next.status = STAT_EXHAUSTED;
                end
                else
                begin
                    res_next.offset        = pl_res.offset;
                    res_next.granted_bytes = size_reg;
                    res_next.status        = STAT_OK;
                    if (pl_res.remain != '0)
                    begin
                        if (cur_cnt_reg < CW'(MAX_HOLES))
                        begin
                            hole_we         = 1'b1;
                            hole_waddr      = {scope_idx, cur_cnt_reg[HW-1:0]};
                            hole_wdata.base = cur_sp_reg[15:0];
                            hole_wdata.free = pl_res.remain;
                            cur_cnt_next    = cur_cnt_reg + CW'(1);
                        end
                        else
                        begin
                            res_next.status = STAT_DROPPED;
                        end
                    end
                    cur_sp_next = cur_sp_reg - $signed({13'd0, SLOT_BYTES});
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

// ===== sv/stack_slot_first_fit_allocator.sv =====
// Top level of the stack slot first-fit allocator: size registers and sequencer.
// Depends on sfa_pkg and sfa_ctrl.
//
//  Channel   Ports                               Transaction
//  ------    ---------------------------------   ------------------------------
//  command   start, busy, cmd                    start high while busy is low
//  result    result_valid, result                one cycle with result_valid high
//  config    cfg_we, cfg_addr, cfg_wdata         cfg_we high, no wait
//
// Open and close transactions give their result in the cycle after acceptance;
// a close that returns to an outer scope keeps busy high while the outer scope is reloaded.
// An allocation scans the scope's n holes through the single read port of the
// hole memory, one per cycle, up to the end of the list on a miss and up to hole h
// on a hit in hole h. A hit that fills its hole also moves the holes behind it
// down, one per cycle.
// Reset gives one open scope with an empty hole list; no clearing pass is run.
// The result receiver cannot stall; each result is shown for one cycle.
`default_nettype none

module stack_slot_first_fit_allocator
    import sfa_pkg::*;
#(
    parameter int MAX_SCOPES = DEF_MAX_SCOPES,
    parameter int MAX_HOLES  = DEF_MAX_HOLES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_item_t   cmd,
    output logic       result_valid,
    output out_item_t  result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [3:0] cfg_wdata
);

    logic [3:0] char_bytes_reg;
    logic [3:0] int_bytes_reg;
    logic [3:0] float_bytes_reg;
    logic [3:0] raw_size;
    logic [3:0] req_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_bytes_reg  <= 4'd1;
            int_bytes_reg   <= 4'd4;
            float_bytes_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CHAR_BYTES:  char_bytes_reg  <= cfg_wdata;
                REG_INT_BYTES:   int_bytes_reg   <= cfg_wdata;
                REG_FLOAT_BYTES: float_bytes_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.var_kind)
            KIND_INT:   raw_size = int_bytes_reg;
            KIND_FLOAT: raw_size = float_bytes_reg;
            default:    raw_size = char_bytes_reg;
        endcase
        if (raw_size == 4'd0)
        begin
            req_size = MIN_SIZE;
        end
        else if (raw_size > SLOT_BYTES)
        begin
            req_size = SLOT_BYTES;
        end
        else
        begin
            req_size = raw_size;
        end
    end

    sfa_ctrl #(
        .MAX_SCOPES (MAX_SCOPES),
        .MAX_HOLES  (MAX_HOLES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .req_size     (req_size),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== sv/sfa_checker.sv =====
// Port-level checks of the allocator and the bind that attaches them.
// Depends on sfa_pkg and stack_slot_first_fit_allocator.
`default_nettype none

module sfa_checker
    import sfa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input in_item_t  cmd,
    input logic      result_valid,
    input out_item_t result
);

    a_scope_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op != OP_ALLOC) |=> result_valid)
        else $error("scope transaction gave no result in the next cycle");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted transaction");

    a_grant_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.granted_bytes != 4'd0) |->
        (result.offset < 0 && result.granted_bytes <= SLOT_BYTES &&
         (result.status == STAT_OK || result.status == STAT_DROPPED)))
        else $error("granted variable has a bad offset, size or status");

    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == STAT_EXHAUSTED ||
                          result.status == STAT_FULL ||
                          result.status == STAT_EMPTY)) |->
        (result.offset == 16'sd0 && result.granted_bytes == 4'd0))
        else $error("error result carries a placement");

endmodule

bind stack_slot_first_fit_allocator sfa_checker u_sfa_checker (.*);

`default_nettype wire

// ===== bench/stack_slot_first_fit_allocator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the stack slot first-fit allocator: a directed table
// and random transactions, each checked against a local model or the table's own values.
// Depends on sfa_pkg and stack_slot_first_fit_allocator.

module stack_slot_first_fit_allocator_tb;
    import sfa_pkg::*;

    localparam int MAX_SCOPES   = DEF_MAX_SCOPES;
    localparam int MAX_HOLES    = DEF_MAX_HOLES;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 40;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 85;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // For configuration rows, op holds the register index and value the data.
    typedef struct packed {
        row_kind_t          rk;
        logic [1:0]         op;
        logic [1:0]         var_kind;
        logic [3:0]         value;
        logic [7:0]         reps;
        logic               check;
        logic signed [15:0] w_offset;
        logic [3:0]         w_bytes;
        logic [2:0]         w_status;
    } stim_row_t;

    localparam int NUM_ROWS = 23;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_ITEM, OP_ALLOC,  KIND_CHAR,  4'd0,  8'd1,  1'b1, -16'sd1, 4'd1, STAT_OK},
        '{ROW_ITEM, OP_ALLOC,  KIND_INT,   4'd0,  8'd1,  1'b0, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_ALLOC,  KIND_FLOAT, 4'd0,  8'd1,  1'b0, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_UNUSED, KIND_CHAR,  4'd0,  8'd1,  1'b1, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_ALLOC,  KIND_NONE,  4'd0,  8'd1,  1'b1, 16'sd0,  4'd0, STAT_OK},
        '{ROW_CFG,  REG_CHAR_BYTES,  KIND_CHAR, 4'd0,  8'd1, 1'b0, 16'sd0, 4'd0, STAT_OK},
        '{ROW_CFG,  REG_INT_BYTES,   KIND_CHAR, 4'd15, 8'd1, 1'b0, 16'sd0, 4'd0, STAT_OK},
        '{ROW_CFG,  REG_FLOAT_BYTES, KIND_CHAR, 4'd2,  8'd1, 1'b0, 16'sd0, 4'd0, STAT_OK},
        '{ROW_ITEM, OP_ALLOC,  KIND_CHAR,  4'd0,  8'd1,  1'b0, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_ALLOC,  KIND_INT,   4'd0,  8'd1,  1'b0, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_ALLOC,  KIND_FLOAT, 4'd0,  8'd1,  1'b0, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_CLOSE,  KIND_INT,   4'd0,  8'd1,  1'b0, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_CLOSE,  KIND_NONE,  4'd0,  8'd1,  1'b1, 16'sd0,  4'd0, STAT_EMPTY},
        '{ROW_ITEM, OP_ALLOC,  KIND_FLOAT, 4'd0,  8'd1,  1'b1, 16'sd0,  4'd0, STAT_EMPTY},
        '{ROW_ITEM, OP_OPEN,   KIND_FLOAT, 4'd0,  8'd1,  1'b1, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_OPEN,   KIND_CHAR,  4'd0,  8'd15, 1'b1, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_OPEN,   KIND_NONE,  4'd0,  8'd1,  1'b1, 16'sd0,  4'd0, STAT_FULL},
        '{ROW_CFG,  REG_INT_BYTES,   KIND_CHAR, 4'd5,  8'd1, 1'b0, 16'sd0, 4'd0, STAT_OK},
        '{ROW_ITEM, OP_ALLOC,  KIND_INT,   4'd0,  8'd17, 1'b0, 16'sd0,  4'd0, STAT_OK},
        '{ROW_CFG,  REG_FLOAT_BYTES, KIND_CHAR, 4'd3,  8'd1, 1'b0, 16'sd0, 4'd0, STAT_OK},
        '{ROW_ITEM, OP_ALLOC,  KIND_FLOAT, 4'd0,  8'd17, 1'b0, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_CLOSE,  KIND_FLOAT, 4'd0,  8'd16, 1'b0, 16'sd0,  4'd0, STAT_OK},
        '{ROW_ITEM, OP_OPEN,   KIND_INT,   4'd0,  8'd1,  1'b1, 16'sd0,  4'd0, STAT_OK}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_item_t   cmd;
    logic       result_valid;
    out_item_t  result;
    logic       cfg_we;
    logic [1:0] cfg_addr;
    logic [3:0] cfg_wdata;

    logic [3:0]  mdl_char_bytes;
    logic [3:0]  mdl_int_bytes;
    logic [3:0]  mdl_float_bytes;
    int unsigned frame_depth;
    int          frame_sp  [MAX_SCOPES];
    int unsigned hole_cnt  [MAX_SCOPES];
    int          hole_off  [MAX_SCOPES][MAX_HOLES];
    int          hole_room [MAX_SCOPES][MAX_HOLES];

    out_item_t pending_layout[$];
    int        fail_count = 0;
    int        stall_cycles = 0;

    stack_slot_first_fit_allocator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic int kind_size(logic [1:0] kind);
        int sz;
        case (kind)
            KIND_CHAR: sz = mdl_char_bytes;
            KIND_INT:  sz = mdl_int_bytes;
            default:   sz = mdl_float_bytes;
        endcase
        if (sz == 0) sz = 1;
        if (sz > 8) sz = 8;
        return sz;
    endfunction

    // Places sz bytes at the top of room bytes above base, aligned down for 2, 4 and 8.
    function automatic int fit_top(input int base, input int room, input int sz,
                                   output int used);
        int off;
        int extra;
        off  = base + room - sz;
        used = sz;
        if (sz == 2 || sz == 4 || sz == 8)
        begin
            extra = off & (sz - 1);
            off  -= extra;
            used += extra;
        end
        return off;
    endfunction

    function automatic out_item_t lay_out_item(in_item_t it);
        out_item_t   r;
        int unsigned s;
        int unsigned n;
        int unsigned h;
        int unsigned j;
        int          sz;
        int          off;
        int          used;
        int          sp;
        bit          placed;
        r = '0;
        case (it.op)
            OP_OPEN:
                if (frame_depth >= MAX_SCOPES)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    frame_sp[frame_depth] = -8;
                    hole_cnt[frame_depth] = 0;
                    frame_depth++;
                end
            OP_CLOSE:
                if (frame_depth == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    frame_depth--;
                    sp = frame_sp[frame_depth];
                    if (sp < -32768) sp = -32768;
                    r.offset = sp[15:0];
                end
            OP_ALLOC:
                if (frame_depth == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else if (it.var_kind != KIND_NONE)
                begin
                    s      = frame_depth - 1;
                    n      = hole_cnt[s];
                    sz     = kind_size(it.var_kind);
                    placed = 1'b0;
                    for (h = 0; h < n && !placed; h++)
                    begin
                        if (hole_room[s][h] >= sz)
                        begin
                            off = fit_top(hole_off[s][h], hole_room[s][h], sz, used);
                            hole_room[s][h] -= used;
                            if (hole_room[s][h] == 0)
                            begin
                                for (j = h; j + 1 < n; j++)
                                begin
                                    hole_off[s][j]  = hole_off[s][j + 1];
                                    hole_room[s][j] = hole_room[s][j + 1];
                                end
                                hole_cnt[s] = n - 1;
                            end
                            r.offset        = off[15:0];
                            r.granted_bytes = sz[3:0];
                            placed          = 1'b1;
                        end
                    end
                    if (!placed)
                    begin
                        if (frame_sp[s] < -32768)
                        begin
                            r.status = STAT_EXHAUSTED;
                        end
                        else
                        begin
                            if (sz == 8)
                            begin
                                off = frame_sp[s];
                            end
                            else
                            begin
                                off = fit_top(frame_sp[s], 8, sz, used);
                                if (n < MAX_HOLES)
                                begin
                                    hole_off[s][n]  = frame_sp[s];
                                    hole_room[s][n] = 8 - used;
                                    hole_cnt[s]     = n + 1;
                                end
                                else
                                begin
                                    r.status = STAT_DROPPED;
                                end
                            end
                            frame_sp[s]    -= 8;
                            r.offset        = off[15:0];
                            r.granted_bytes = sz[3:0];
                        end
                    end
                end
            default: ;
        endcase
        return r;
    endfunction

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_rest(bit allowed);
        if (allowed && $urandom_range(0, 5) == 0)
            hold_off($urandom_range(1, 19));
    endtask

    task automatic issue(in_item_t it, bit check, out_item_t want);
        out_item_t predicted;
        start <= 1'b1;
        cmd   <= it;
        do @(posedge clk); while (busy !== 1'b0);
        predicted = lay_out_item(it);
        pending_layout.insert(pending_layout.size(), check ? want : predicted);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_layout.size() != 0) @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_size(logic [1:0] idx, logic [3:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CHAR_BYTES:  mdl_char_bytes  = val;
            REG_INT_BYTES:   mdl_int_bytes   = val;
            REG_FLOAT_BYTES: mdl_float_bytes = val;
            default: ;
        endcase
    endtask

    function automatic logic [3:0] pick_size();
        case ($urandom_range(0, 5))
            0:       return 4'd0;
            1:       return 4'd1;
            2:       return 4'd8;
            3:       return 4'd15;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("stack_slot_first_fit_allocator test failed");
            $finish;
        end
        else if (rst_n && result_valid === 1'b1)
        begin
            if (pending_layout.size() == 0)
            begin
                $error("result transaction with nothing pending: %p", result);
                fail_count++;
            end
            else
            begin
                want = pending_layout.pop_front();
                if (result.offset !== want.offset)
                begin
                    $error("offset: expected %0d, got %0d", want.offset, result.offset);
                    fail_count++;
                end
                if (result.granted_bytes !== want.granted_bytes)
                begin
                    $error("granted_bytes: expected %0d, got %0d",
                           want.granted_bytes, result.granted_bytes);
                    fail_count++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t row;
        in_item_t  it;
        out_item_t want;
        int        pick;
        int        i;
        int        k;
        int        ph;

        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        mdl_char_bytes  = 4'd1;
        mdl_int_bytes   = 4'd4;
        mdl_float_bytes = 4'd4;
        frame_depth = 1;
        for (i = 0; i < MAX_SCOPES; i++)
        begin
            frame_sp[i] = 0;
            hole_cnt[i] = 0;
        end
        frame_sp[0] = -8;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.rk == ROW_CFG)
            begin
                drain();
                write_size(row.op, row.value);
            end
            else
            begin
                for (k = 0; k < row.reps; k++)
                begin
                    it.op       = row.op;
                    it.var_kind = row.var_kind;
                    want        = '{row.w_offset, row.w_bytes, row.w_status};
                    issue(it, row.check, want);
                    maybe_rest(1'b1);
                end
            end
        end

        want = '0;
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            write_size(REG_CHAR_BYTES, pick_size());
            write_size(REG_INT_BYTES, pick_size());
            write_size(REG_FLOAT_BYTES, pick_size());
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (frame_depth == 0)
                    it.op = pick < 70 ? OP_OPEN : (pick < 85 ? OP_ALLOC : OP_CLOSE);
                else if (pick < 68)
                    it.op = OP_ALLOC;
                else if (pick < 82)
                    it.op = OP_OPEN;
                else if (pick < 96)
                    it.op = OP_CLOSE;
                else
                    it.op = OP_UNUSED;
                if ($urandom_range(0, 19) == 0)
                    it.var_kind = KIND_NONE;
                else
                    it.var_kind = 2'($urandom_range(0, 2));
                issue(it, 1'b0, want);
                maybe_rest(ph < RAND_PHASES - 1);
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("stack_slot_first_fit_allocator test passed");
        else
            $display("stack_slot_first_fit_allocator test failed");
        $finish;
    end

endmodule
